FILE: rtl/pdo_pkg.sv
// Shared payload types and constants of the PPS disciplined oscillator PID unit.
`default_nettype none

package pdo_pkg;

  localparam logic [2:0] OUTCOME_STORED  = 3'd0;
  localparam logic [2:0] OUTCOME_STEPPED = 3'd1;
  localparam logic [2:0] OUTCOME_STEERED = 3'd2;
  localparam logic [2:0] OUTCOME_RANGE   = 3'd3;
  localparam logic [2:0] OUTCOME_HOUSE   = 3'd4;

  localparam logic [2:0] REG_TICKS = 3'd0;
  localparam int unsigned NUM_GAINS = 6;

  localparam logic [31:0] TICKS_RESET = 32'd10000000;
  // Reciprocal of 1000 scaled by 2^38; the product shifted down by 38 is exact for any 32-bit
  // value.
  localparam logic [31:0] RANGE_RECIP = 32'd274877907;
  localparam logic [11:0] DAC_MAX     = 12'd4095;
  localparam logic signed [33:0] STEP_LIMIT = 34'sd10000;

  typedef struct packed {
    logic        kind;
    logic [31:0] capture_value;
    logic [31:0] counter_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        dac_write;
    logic [11:0] dac_value;
    logic        counter_load;
    logic [31:0] counter_new;
    logic        reschedule;
    logic        pulse_present;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/pdo_div.sv
// Bit-serial restoring divider giving the remainder, one quotient bit per cycle.
`default_nettype none

module pdo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] remainder
);

  logic [32:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial   = {rem_r, q_r[32]};
    ge      = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[31:0] : trial[31:0];
    q_nxt   = {q_r[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: rtl/pdo_mul.sv
// Shift-and-add signed multiplier returning floor(a * g / 2^16) for a Q16.16 gain.
`default_nettype none

module pdo_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] a,
  input  logic signed [31:0] g,
  output logic               busy,
  output logic signed [63:0] term
);

  logic signed [79:0] m_r;
  logic signed [79:0] acc_r, acc_nxt;
  logic [31:0]        g_r;
  logic [4:0]         cnt_r;
  logic               busy_r;

  // The top bit of the gain has negative weight, so its partial product is subtracted.
  always_comb begin
    acc_nxt = acc_r;
    if (g_r[0]) begin
      acc_nxt = (cnt_r == 5'd31) ? acc_r - m_r : acc_r + m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      m_r    <= 80'(a);
      g_r    <= g;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      m_r   <= m_r <<< 1;
      g_r   <= g_r >> 1;
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign term = acc_r[79:16];

endmodule

`default_nettype wire

FILE: rtl/pps_disciplined_oscillator_pid_unit.sv
// Top level of the PPS disciplined oscillator controller with cascaded phase and period PIDs.
//
// Usage: each input transfer on in_* carries either a 1PPS capture (kind 0) or a
// housekeeping tick (kind 1), and produces exactly one result transfer on out_*.
// Configuration registers are written through cfg_* (index 0 ticks per second, which
// also reloads the period setpoint, then the six Q16.16 gains); cfg_ready is always
// high and writes are meant to happen while the block is idle.
// A housekeeping tick or a first capture goes straight to the output register. Any
// other capture first takes a serial remainder against ticks per second; one that
// steps the counter then finishes. A capture that runs the loops passes through the
// phase PID and the period range check, and through the period PID as well when it
// steers; each PID term is a shift-and-add multiply on the one shared multiplier.
// The period window, a thousandth of ticks per second, comes from a constant
// reciprocal product and is combinational. in_ready is high only while the sequencer
// is idle, so no new item is taken until the last one is finished. The finished
// result sits in an output register; the sequencer returns to idle as soon as it has
// been placed there, so a stalled receiver holds only that register, and a further
// result waits in the sequencer until the register is free. Synchronous active-low
// reset clears all loop state, sets ticks per second to ten million and all gains to zero.
`default_nettype none

module pps_disciplined_oscillator_pid_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdo_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import pdo_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_PHASE, ST_WAIT_PHASE, ST_MUL_GO, ST_MUL_WAIT,
    ST_SETPT, ST_RANGE, ST_DRIVE, ST_OUT
  } state_t;

  function automatic logic [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh7FFFFFFF) begin
      return 32'h7FFFFFFF;
    end
    if (v < -66'sh80000000) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  state_t state_r;

  logic [31:0]        tps_r;
  logic [31:0]        gain_r [NUM_GAINS];
  logic [31:0]        last_cap_r;
  logic signed [31:0] phase_prev_r;
  logic signed [47:0] phase_sum_r;
  logic [32:0]        setpoint_r;
  logic signed [31:0] period_prev_r;
  logic signed [47:0] period_sum_r;
  logic               pulse_seen_r;
  logic [11:0]        drive_r;

  logic [31:0]        now_r;
  logic [31:0]        period_r;
  logic signed [33:0] err_r;
  logic signed [34:0] der_r;
  logic signed [65:0] pid_r;
  logic [1:0]         k_r;
  logic               loop_r;
  out_item_t          res_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // Shared units.
  logic               div_start;
  logic [32:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic               div_busy;
  logic [31:0]        div_rem;
  logic               mul_start;
  logic signed [47:0] mul_a;
  logic signed [31:0] mul_g;
  logic               mul_busy;
  logic signed [63:0] mul_term;
  logic [2:0]         gain_sel;

  // Per-state arithmetic.
  logic signed [33:0] perr;
  logic               small_err;
  logic [63:0]        win_prod;
  logic [31:0]        win_half;
  logic [32:0]        win_lo, win_hi;
  logic               in_window;
  logic signed [33:0] per_diff;
  logic signed [31:0] per_err;
  logic signed [31:0] trim;
  logic signed [33:0] sp;
  logic signed [65:0] pid_sum;
  logic [11:0]        drive_val;

  logic in_xfer, out_xfer, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Nearest whole second: remainder of capture plus half a second.
  assign div_start    = (state_r == ST_DIV_PHASE);
  assign div_dividend = {1'b0, last_cap_r} + {2'b0, tps_r[31:1]};
  assign div_divisor  = (tps_r == '0) ? 32'd1 : tps_r;

  // The phase error is half a second minus the remainder, which avoids rebuilding the rounded value.
  assign perr      = $signed({3'b0, tps_r[31:1]}) - $signed({2'b0, div_rem});
  assign small_err = (perr <= STEP_LIMIT) && (perr >= -STEP_LIMIT);

  assign gain_sel  = (loop_r ? 3'd3 : 3'd0) + {1'b0, k_r};
  assign mul_start = (state_r == ST_MUL_GO);
  assign mul_g     = gain_r[gain_sel];
  always_comb begin
    unique case (k_r)
      2'd0:    mul_a = 48'(err_r);
      2'd1:    mul_a = loop_r ? period_sum_r : phase_sum_r;
      default: mul_a = 48'(der_r);
    endcase
  end
  assign pid_sum = pid_r + 66'(mul_term);

  // A thousandth of ticks per second always fits in 26 bits.
  assign win_prod  = {32'b0, tps_r} * {32'b0, RANGE_RECIP};
  assign win_half  = {6'b0, win_prod[63:38]};
  assign win_lo    = {1'b0, tps_r} - {1'b0, win_half};
  assign win_hi    = {1'b0, tps_r} + {1'b0, win_half};
  assign in_window = ({1'b0, period_r} > win_lo) && ({1'b0, period_r} < win_hi);
  assign per_diff  = $signed({1'b0, setpoint_r}) - $signed({2'b0, period_r});
  assign per_err   = clamp32(66'(per_diff));
  assign trim      = clamp32(pid_r);
  assign sp        = $signed({2'b0, tps_r}) + 34'(trim);

  // The drive code is the period loop sum held to the DAC range.
  always_comb begin
    priority if (pid_r < 0) begin
      drive_val = '0;
    end else if (pid_r > 66'(DAC_MAX)) begin
      drive_val = DAC_MAX;
    end else begin
      drive_val = pid_r[11:0];
    end
  end

  pdo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  pdo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .g     (mul_g),
    .busy  (mul_busy),
    .term  (mul_term)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tps_r         <= TICKS_RESET;
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain_r[i] <= '0;
      end
      last_cap_r    <= '0;
      phase_prev_r  <= '0;
      phase_sum_r   <= '0;
      setpoint_r    <= {1'b0, TICKS_RESET};
      period_prev_r <= '0;
      period_sum_r  <= '0;
      pulse_seen_r  <= 1'b0;
      drive_r       <= '0;
      out_valid_r   <= 1'b0;
      k_r           <= '0;
      loop_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TICKS) begin
          tps_r      <= cfg_data;
          setpoint_r <= {1'b0, cfg_data};
        end else if (cfg_index <= 3'(NUM_GAINS)) begin
          gain_r[cfg_index - 3'd1] <= cfg_data;
        end
      end
      // A result placed in the output register in the same cycle keeps out_valid high.
      if (out_xfer && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            now_r <= in_data.counter_now;
            if (in_data.kind) begin
              res_r <= '{outcome: OUTCOME_HOUSE, dac_value: drive_r, reschedule: 1'b1,
                         pulse_present: pulse_seen_r, default: '0};
              pulse_seen_r <= 1'b0;
              state_r      <= ST_OUT;
            end else begin
              res_r <= '{outcome: OUTCOME_STORED, dac_value: drive_r, default: '0};
              pulse_seen_r <= 1'b1;
              last_cap_r   <= in_data.capture_value;
              period_r     <= in_data.capture_value - last_cap_r;
              if (last_cap_r == '0) begin
                state_r <= ST_OUT;
              end else begin
                state_r <= ST_DIV_PHASE;
              end
            end
          end
        end
        ST_DIV_PHASE: state_r <= ST_WAIT_PHASE;
        ST_WAIT_PHASE: begin
          if (!div_busy) begin
            if (!small_err) begin
              res_r <= '{outcome: OUTCOME_STEPPED, dac_value: drive_r, counter_load: 1'b1,
                         counter_new: now_r + perr[31:0], reschedule: 1'b1, default: '0};
              last_cap_r   <= now_r + perr[31:0];
              phase_prev_r <= '0;
              phase_sum_r  <= '0;
              state_r      <= ST_OUT;
            end else begin
              phase_sum_r <= sat48(49'(phase_sum_r) + 49'(perr));
              err_r       <= perr;
              der_r       <= 35'(perr) - 35'(phase_prev_r);
              pid_r       <= '0;
              k_r         <= '0;
              loop_r      <= 1'b0;
              state_r     <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: state_r <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (!mul_busy) begin
            pid_r <= pid_sum;
            if (k_r == 2'd2) begin
              state_r <= loop_r ? ST_DRIVE : ST_SETPT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_SETPT: begin
          setpoint_r   <= sp[33] ? '0 : sp[32:0];
          phase_prev_r <= err_r[31:0];
          state_r      <= ST_RANGE;
        end
        ST_RANGE: begin
          if (!div_busy) begin
            if (in_window) begin
              period_sum_r <= sat48(49'(period_sum_r) + 49'(per_err));
              err_r        <= 34'(per_err);
              der_r        <= 35'(per_err) - 35'(period_prev_r);
              pid_r        <= '0;
              k_r          <= '0;
              loop_r       <= 1'b1;
              state_r      <= ST_MUL_GO;
            end else begin
              res_r.outcome <= OUTCOME_RANGE;
              state_r       <= ST_OUT;
            end
          end
        end
        ST_DRIVE: begin
          drive_r       <= drive_val;
          res_r         <= '{outcome: OUTCOME_STEERED, dac_write: 1'b1, dac_value: drive_val,
                             default: '0};
          period_prev_r <= err_r[31:0];
          state_r       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_dac_only_steered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dac_write |-> out_data.outcome == OUTCOME_STEERED)
    else $error("DAC write without steering");
  a_load_reschedules: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.counter_load |-> out_data.reschedule)
    else $error("counter load without reschedule");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mul_busy)
    else $error("multiplier still busy while idle");
`endif

endmodule

`default_nettype wire

FILE: bench/pps_disciplined_oscillator_pid_unit_test.sv
// Self-checking bench of the PPS disciplined oscillator PID unit with its own loop predictor.
`default_nettype none

module pps_disciplined_oscillator_pid_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdo_pkg::*;

  // Register indexes of the six gains, following the ticks-per-second register.
  localparam logic [2:0] REG_PHASE_P  = 3'd1;
  localparam logic [2:0] REG_PHASE_I  = 3'd2;
  localparam logic [2:0] REG_PHASE_D  = 3'd3;
  localparam logic [2:0] REG_PERIOD_P = 3'd4;
  localparam logic [2:0] REG_PERIOD_I = 3'd5;
  localparam logic [2:0] REG_PERIOD_D = 3'd6;

  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -64'sd140737488355328;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pps_disciplined_oscillator_pid_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The clock runs with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The predictor keeps its own copy of the configuration and of every piece of loop state.
  logic [31:0] model_tps = TICKS_RESET;
  int          model_gain [6] = '{0, 0, 0, 0, 0, 0};
  logic [31:0] last_capture = '0;
  int          phase_err_prev = 0;
  longint      phase_sum = 0;
  longint      period_setpoint = longint'(TICKS_RESET);
  int          period_err_prev = 0;
  longint      period_sum = 0;
  bit          pulse_seen = 1'b0;
  logic [11:0] drive_hold = '0;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        error_count = 0;
  int        results_seen = 0;

  // Saturates a wide signed value into the range lo..hi.
  function automatic logic signed [95:0] clamp_wide(logic signed [95:0] v, longint lo, longint hi);
    logic signed [95:0] l;
    logic signed [95:0] h;
    l = lo;
    h = hi;
    return (v < l) ? l : ((v > h) ? h : v);
  endfunction

  // One Q16.16 gain term, floor(operand * gain / 2^16), evaluated wide enough to be exact.
  function automatic logic signed [95:0] gain_term(longint operand, int g);
    logic signed [95:0] a;
    logic signed [95:0] k;
    a = operand;
    k = g;
    return (a * k) >>> 16;
  endfunction

  // Works out the result of one accepted item and advances the loop state accordingly.
  function automatic out_item_t predict_discipline(in_item_t item);
    out_item_t r;
    longint unsigned t;
    longint unsigned d;
    longint unsigned nearest;
    longint perr;
    longint der;
    longint e;
    longint lo;
    longint hi;
    logic [31:0] period;
    logic signed [95:0] acc;
    r = '0;
    t = model_tps;
    d = (t == 0) ? 64'd1 : t;
    if (item.kind) begin
      r.outcome = OUTCOME_HOUSE;
      r.reschedule = 1'b1;
      r.pulse_present = pulse_seen;
      pulse_seen = 1'b0;
    end else begin
      pulse_seen = 1'b1;
      if (last_capture == 0) begin
        last_capture = item.capture_value;
        r.outcome = OUTCOME_STORED;
      end else begin
        period = item.capture_value - last_capture;
        last_capture = item.capture_value;
        // Rounding to the nearest second is done in 64 bits, so it never wraps.
        nearest = ({32'd0, item.capture_value} + t / 2) / d * d;
        perr = longint'(nearest) - longint'({32'd0, item.capture_value});
        if (perr > 10000 || perr < -10000) begin
          r.counter_new = item.counter_now + perr[31:0];
          r.counter_load = 1'b1;
          r.reschedule = 1'b1;
          r.outcome = OUTCOME_STEPPED;
          phase_err_prev = 0;
          phase_sum = 0;
          last_capture = r.counter_new;
        end else begin
          phase_sum = longint'(clamp_wide(phase_sum + perr, SUM_LO, SUM_HI));
          der = perr - phase_err_prev;
          acc = gain_term(perr, model_gain[0]) + gain_term(phase_sum, model_gain[1])
              + gain_term(der, model_gain[2]);
          acc = clamp_wide(acc, -64'sd2147483648, 64'sd2147483647);
          period_setpoint = longint'(t) + longint'(acc);
          if (period_setpoint < 0) begin
            period_setpoint = 0;
          end
          phase_err_prev = int'(perr);
          lo = longint'(t) - longint'(t / 1000);
          hi = longint'(t) + longint'(t / 1000);
          // The phase loop has already moved the setpoint even if the period is rejected here.
          if (longint'({32'd0, period}) > lo && longint'({32'd0, period}) < hi) begin
            e = longint'(clamp_wide(period_setpoint - longint'({32'd0, period}),
                                    -64'sd2147483648, 64'sd2147483647));
            period_sum = longint'(clamp_wide(period_sum + e, SUM_LO, SUM_HI));
            der = e - period_err_prev;
            acc = gain_term(e, model_gain[3]) + gain_term(period_sum, model_gain[4])
                + gain_term(der, model_gain[5]);
            acc = clamp_wide(acc, 0, 4095);
            period_err_prev = int'(e);
            drive_hold = acc[11:0];
            r.dac_write = 1'b1;
            r.outcome = OUTCOME_STEERED;
          end else begin
            r.outcome = OUTCOME_RANGE;
          end
        end
      end
    end
    r.dac_value = drive_hold;
    return r;
  endfunction

  // Driver: offers queued items, holding each until its transfer, with random gaps between them.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_discipline(in_data));
        send_gap = ($urandom_range(0, 99) < 3) ? $urandom_range(20, 300) :
                   (($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 3));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation and stalls at random.
  // Twice in the run the receiver holds off for a long stretch so that the block backs up.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    out_item_t want;
    logic ready_next;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_data.outcome);
            error_count++;
          end
          if (out_data.dac_write !== want.dac_write) begin
            $error("dac_write: expected %0d, got %0d", want.dac_write, out_data.dac_write);
            error_count++;
          end
          if (out_data.dac_value !== want.dac_value) begin
            $error("dac_value: expected %0d, got %0d", want.dac_value, out_data.dac_value);
            error_count++;
          end
          if (out_data.counter_load !== want.counter_load) begin
            $error("counter_load: expected %0d, got %0d", want.counter_load,
                   out_data.counter_load);
            error_count++;
          end
          if (out_data.counter_new !== want.counter_new) begin
            $error("counter_new: expected %0h, got %0h", want.counter_new, out_data.counter_new);
            error_count++;
          end
          if (out_data.reschedule !== want.reschedule) begin
            $error("reschedule: expected %0d, got %0d", want.reschedule, out_data.reschedule);
            error_count++;
          end
          if (out_data.pulse_present !== want.pulse_present) begin
            $error("pulse_present: expected %0d, got %0d", want.pulse_present,
                   out_data.pulse_present);
            error_count++;
          end
        end
        if (results_seen == 100 || results_seen == 1200) begin
          hold_left = 3000;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if ($urandom_range(0, 99) < 25) begin
          stall_left = ($urandom_range(0, 99) < 4) ? $urandom_range(30, 120) :
                       $urandom_range(1, 4);
        end
      end
      out_ready <= ready_next;
    end
  end

  // Stimulus helpers: a running second boundary keeps most captures close to the true second.
  logic [31:0] stim_tps = TICKS_RESET;
  logic [31:0] stim_base = '0;

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TICKS) begin
      model_tps = value;
      period_setpoint = longint'({32'd0, value});
      stim_tps = value;
    end else begin
      model_gain[idx - 1] = int'(value);
    end
  endtask

  task automatic write_all(logic [31:0] tps, int pp, int pi, int pd, int qp, int qi, int qd);
    write_reg(REG_TICKS, tps);
    write_reg(REG_PHASE_P, pp);
    write_reg(REG_PHASE_I, pi);
    write_reg(REG_PHASE_D, pd);
    write_reg(REG_PERIOD_P, qp);
    write_reg(REG_PERIOD_I, qi);
    write_reg(REG_PERIOD_D, qd);
  endtask

  function automatic int small_gain();
    return int'($urandom_range(0, 32'h40000)) - 32'h20000;
  endfunction

  task automatic queue_item(logic kind, logic [31:0] cap, logic [31:0] now);
    in_item_t it;
    it.kind = kind;
    it.capture_value = cap;
    it.counter_now = now;
    pending_items.push_back(it);
  endtask

  // Mostly captures near the next second with modest jitter; the rest are ticks and noise.
  task automatic queue_random_item();
    int pick;
    int jitter;
    logic [31:0] cap;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      queue_item(1'b1, $urandom, $urandom);
    end else if (pick < 20) begin
      cap = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      queue_item(1'b0, cap, $urandom);
    end else if (pick < 22) begin
      stim_base = $urandom;
    end else begin
      jitter = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 16000)) - 8000 :
                                               int'($urandom_range(0, 60000)) - 30000;
      cap = stim_base + jitter;
      queue_item(1'b0, cap, cap + $urandom_range(0, 1000));
      stim_base = stim_base + stim_tps;
    end
  endtask

  task automatic queue_random_phase();
    stim_base = stim_tps * $urandom_range(1, 3);
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      queue_random_item();
    end
  endtask

  // Waits until every item has been taken and answered, then lets the block settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] b;
    logic [31:0] t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under moderate gains at ten million ticks per second.
    write_all(32'd10000000, 32'h4000, 32'h40, 32'h1000, 32'h2000, 32'h10, 32'h800);
    t = stim_tps;
    b = t * 5;
    queue_item(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);  // tick with no pulse seen
    queue_item(1'b0, 32'd0, 32'd0);                // a capture of zero still marks a pulse
    queue_item(1'b1, 32'd0, 32'd0);                // tick reporting that pulse
    queue_item(1'b0, b, b + 7);                    // first real capture is only stored
    queue_item(1'b0, b + t + 5, b + t + 40);       // steered
    queue_item(1'b0, b + 2 * t - 3, b + 2 * t);    // steered
    queue_item(1'b0, b + 3 * t + 9000, b + 3 * t + 9100);    // steered near the edge
    queue_item(1'b0, b + 4 * t - 9000, b + 4 * t);           // phase small, period rejected
    queue_item(1'b0, b + 5 * t + 200000, b + 5 * t + 200100); // large error steps the counter
    queue_item(1'b0, b + 6 * t + 100, b + 6 * t + 150);      // back in lock after the step
    queue_item(1'b0, b + 7 * t + 20000, 32'd20000);          // step lands the counter on zero
    queue_item(1'b0, b + 8 * t, b + 8 * t);                  // so this one is only stored
    queue_item(1'b0, b + 9 * t + t / 2, 32'hFFFFFFFF);       // exactly half a second rounds up
    queue_item(1'b0, b + 10 * t - t / 2 + 1, 32'h0);         // just under half a second
    queue_item(1'b0, 32'hFFFFFFFF, 32'h0);
    queue_item(1'b0, 32'h0, 32'hFFFFFFFF);
    queue_item(1'b1, 32'h0, 32'h0);
    queue_item(1'b1, 32'h0, 32'h0);
    wait_idle();
    queue_random_phase();
    wait_idle();

    // Slowest legal timer.
    write_all(32'd1000000, small_gain(), small_gain(), small_gain(),
              small_gain(), small_gain(), small_gain());
    queue_random_phase();
    wait_idle();

    // Fastest legal timer; seconds wrap the 32-bit counter.
    write_all(32'hFFFFFFFF, small_gain(), small_gain(), small_gain(),
              small_gain(), small_gain(), small_gain());
    queue_random_phase();
    wait_idle();

    // Largest positive gains.
    write_all(32'd10000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_random_phase();
    wait_idle();

    // Most negative gains.
    write_all(32'd10000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000);
    queue_random_phase();
    wait_idle();

    // Arbitrary timer rate and gains over the whole range.
    write_all($urandom_range(32'd1000000, 32'hFFFFFFFF), $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
    queue_random_phase();
    wait_idle();

    if (error_count == 0) begin
      $display("pps_disciplined_oscillator_pid_unit test passed");
    end else begin
      $display("pps_disciplined_oscillator_pid_unit test failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20ms;
    $display("pps_disciplined_oscillator_pid_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
